>>> hdl/stk_pkg.sv
package stk_pkg;

    localparam int LEXEME_MAX = 32;
    localparam int LEN_W      = $clog2(LEXEME_MAX + 1);
    localparam int ADDR_W     = $clog2(LEXEME_MAX);

    typedef enum logic [3:0] {
        K_BINOP  = 4'd0,
        K_EQ     = 4'd1,
        K_IDENT  = 4'd2,
        K_NUMBER = 4'd3,
        K_SEMI   = 4'd4,
        K_TERM   = 4'd5,
        K_LPAREN = 4'd6,
        K_RPAREN = 4'd7,
        K_PRINT  = 4'd8,
        K_IS     = 4'd9,
        K_CMP    = 4'd10,
        K_STRING = 4'd11,
        K_TIMES  = 4'd12,
        K_DEF    = 4'd13
    } token_kind_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  lexeme_char;
        logic        char_valid;
        logic        last;
        logic [15:0] line_number;
        logic [15:0] column_count;
        logic        truncated;
    } result_t;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_GT      = 8'h3E;

    // Keywords, tracked as one prefix-match flag each.
    localparam int         KW_COUNT = 4;
    localparam logic [1:0] KW_PRINT = 2'd0;
    localparam logic [1:0] KW_IS    = 2'd1;
    localparam logic [1:0] KW_TIMES = 2'd2;
    localparam logic [1:0] KW_DEF   = 2'd3;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        case (k)
            KW_PRINT: kw_len = 3'd2;
            KW_IS:    kw_len = 3'd2;
            KW_TIMES: kw_len = 3'd5;
            KW_DEF:   kw_len = 3'd3;
            default:  kw_len = 3'd0;
        endcase
    endfunction

    // Byte i of the result holds character i of the keyword.
    function automatic logic [63:0] kw_text(input logic [1:0] k);
        case (k)
            KW_PRINT: kw_text = 64'h3E3E;
            KW_IS:    kw_text = 64'h7369;
            KW_TIMES: kw_text = 64'h73656D6974;
            KW_DEF:   kw_text = 64'h666564;
            default:  kw_text = 64'h0;
        endcase
    endfunction

    function automatic logic kw_hit(input logic [1:0] k, input logic [LEN_W-1:0] pos,
                                    input logic [7:0] c);
        logic [63:0] txt;
        txt    = kw_text(k);
        kw_hit = (pos < LEN_W'(kw_len(k))) && (txt[{pos[2:0], 3'b000} +: 8] == c);
    endfunction

endpackage

>>> hdl/stk_in_if.sv
interface stk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

>>> hdl/stk_out_if.sv
interface stk_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  lexeme_char;
    logic        char_valid;
    logic        last;
    logic [15:0] line_number;
    logic [15:0] column_count;
    logic        truncated;

    modport source (output valid, output token_kind, output lexeme_char, output char_valid,
                    output last, output line_number, output column_count,
                    output truncated, input ready);
    modport sink   (input valid, input token_kind, input lexeme_char, input char_valid,
                    input last, input line_number, input column_count,
                    input truncated, output ready);
endinterface

>>> hdl/source_tokenizer.sv
// Streaming scanner: one source byte, or an end-of-input mark, per item on src;
// tokens leave on res as runs of lexeme characters with kind, line and column,
// or as one item with char_valid low for tokens without a lexeme.
// An item is taken only while the block is idle. An item that finishes a
// token is followed by one output item per lexeme character (or one item
// for a token without lexeme); when the byte is scanned again after the
// token, that scan may emit a token of its own.
// The lexeme memory has one read port and one write port; the character run
// is read from it one entry per cycle while res accepts, and goes through
// the single output register.
// src.ready is high only while no token is being emitted.
// Reset clears the scan state: line 1, column 0, no lexeme, not ended. The
// lexeme memory needs no clearing, since only written entries are read.
// When res stalls, the output register holds its item and the block waits;
// src.ready stays low until the token's last item is loaded and any rescan
// is done. After the end mark every further item on src is accepted and dropped.
module source_tokenizer (
    input  logic      clk,
    input  logic      rst_n,
    stk_in_if.sink    src,
    stk_out_if.source res
);

    localparam int LEN_W  = stk_pkg::LEN_W;
    localparam int ADDR_W = stk_pkg::ADDR_W;

    typedef enum logic [2:0] {M_START, M_ID, M_NUM, M_STR, M_EQ} mode_t;
    typedef enum logic [1:0] {S_IDLE, S_LEX, S_ONE, S_REPROC} state_t;

    state_t                         state_reg, state_next;
    mode_t                          mode_reg, mode_next;
    logic [LEN_W-1:0]               len_reg, len_next;
    logic                           ovf_reg, ovf_next;
    logic [15:0]                    line_reg, line_next;
    logic [15:0]                    col_reg, col_next;
    logic                           ended_reg, ended_next;
    logic [stk_pkg::KW_COUNT-1:0]   kw_reg, kw_next;
    logic [LEN_W-1:0]               emit_len_reg, emit_len_next;
    logic [LEN_W-1:0]               idx_reg, idx_next;
    logic                           trunc_reg, trunc_next;
    logic [3:0]                     kind_reg, kind_next;
    logic [3:0]                     one_kind_reg, one_kind_next;
    logic [7:0]                     one_char_reg, one_char_next;
    logic                           one_cv_reg, one_cv_next;
    logic                           one_trunc_reg, one_trunc_next;
    logic                           reproc_reg, reproc_next;
    logic [7:0]                     held_ch_reg, held_ch_next;
    logic                           held_end_reg, held_end_next;

    logic [7:0]        lex_mem [stk_pkg::LEXEME_MAX];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic              acc;
    logic              out_free;
    logic              load;
    stk_pkg::result_t  item;

    logic              sp_run;
    logic              put_en;
    logic              emit_en;
    logic              emit_lex;
    logic [3:0]        emit_kind;
    logic              reproc_set;
    logic [7:0]        cur_c;
    logic              cur_end;
    logic [3:0]        id_kind;
    logic [LEN_W-1:0]  idx_inc;
    logic              lex_last;

    assign acc       = src.valid && src.ready;
    assign src.ready = (state_reg == S_IDLE);

    assign cur_c   = (state_reg == S_REPROC) ? held_ch_reg : src.ch;
    assign cur_end = (state_reg == S_REPROC) ? held_end_reg : src.end_of_input;

    assign idx_inc  = idx_reg + LEN_W'(1);
    assign lex_last = (idx_inc == emit_len_reg);

    // Keyword flags only count when the whole lexeme has the keyword's length.
    always_comb
    begin
        id_kind = stk_pkg::K_IDENT;
        if (!ovf_reg)
        begin
            if (kw_reg[stk_pkg::KW_PRINT] &&
                len_reg == LEN_W'(stk_pkg::kw_len(stk_pkg::KW_PRINT)))
                id_kind = stk_pkg::K_PRINT;
            else if (kw_reg[stk_pkg::KW_IS] &&
                     len_reg == LEN_W'(stk_pkg::kw_len(stk_pkg::KW_IS)))
                id_kind = stk_pkg::K_IS;
            else if (kw_reg[stk_pkg::KW_TIMES] &&
                     len_reg == LEN_W'(stk_pkg::kw_len(stk_pkg::KW_TIMES)))
                id_kind = stk_pkg::K_TIMES;
            else if (kw_reg[stk_pkg::KW_DEF] &&
                     len_reg == LEN_W'(stk_pkg::kw_len(stk_pkg::KW_DEF)))
                id_kind = stk_pkg::K_DEF;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        ended_next     = ended_reg;
        kw_next        = kw_reg;
        emit_len_next  = emit_len_reg;
        idx_next       = idx_reg;
        trunc_next     = trunc_reg;
        kind_next      = kind_reg;
        one_kind_next  = one_kind_reg;
        one_char_next  = one_char_reg;
        one_cv_next    = one_cv_reg;
        one_trunc_next = one_trunc_reg;
        reproc_next    = reproc_reg;
        held_ch_next   = held_ch_reg;
        held_end_next  = held_end_reg;

        sp_run     = 1'b0;
        put_en     = 1'b0;
        emit_en    = 1'b0;
        emit_lex   = 1'b0;
        emit_kind  = stk_pkg::K_EQ;
        reproc_set = 1'b0;
        load       = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = len_reg[ADDR_W-1:0];
        rd_addr    = '0;

        item.token_kind   = one_kind_reg;
        item.lexeme_char  = one_char_reg;
        item.char_valid   = one_cv_reg;
        item.last         = 1'b1;
        item.line_number  = line_reg;
        item.column_count = col_reg;
        item.truncated    = one_trunc_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (acc && !ended_reg)
                begin
                    if (col_reg != 16'hFFFF)
                        col_next = col_reg + 16'd1;
                    held_ch_next  = src.ch;
                    held_end_next = src.end_of_input;
                    if (!src.end_of_input && src.ch == stk_pkg::CH_NEWLINE)
                    begin
                        if (line_reg != 16'hFFFF)
                            line_next = line_reg + 16'd1;
                    end
                    else
                    begin
                        case (mode_reg)
                            M_ID:
                            begin
                                if (!src.end_of_input &&
                                    (stk_pkg::is_letter(src.ch) || src.ch == stk_pkg::CH_GT))
                                    put_en = 1'b1;
                                else
                                begin
                                    emit_en    = 1'b1;
                                    emit_lex   = 1'b1;
                                    emit_kind  = id_kind;
                                    reproc_set = 1'b1;
                                end
                            end
                            M_NUM:
                            begin
                                if (!src.end_of_input && stk_pkg::is_digit(src.ch))
                                    put_en = 1'b1;
                                else
                                begin
                                    emit_en    = 1'b1;
                                    emit_lex   = 1'b1;
                                    emit_kind  = stk_pkg::K_NUMBER;
                                    reproc_set = 1'b1;
                                end
                            end
                            M_STR:
                            begin
                                if (src.end_of_input)
                                begin
                                    emit_en    = 1'b1;
                                    emit_lex   = 1'b1;
                                    emit_kind  = stk_pkg::K_STRING;
                                    reproc_set = 1'b1;
                                end
                                else if (src.ch == stk_pkg::CH_QUOTE)
                                begin
                                    emit_en   = 1'b1;
                                    emit_lex  = 1'b1;
                                    emit_kind = stk_pkg::K_STRING;
                                end
                                else
                                    put_en = 1'b1;
                            end
                            M_EQ:
                            begin
                                // The second '=' joins the lexeme, then "==" leaves.
                                if (!src.end_of_input && src.ch == stk_pkg::CH_EQUAL)
                                begin
                                    put_en    = 1'b1;
                                    emit_en   = 1'b1;
                                    emit_lex  = 1'b1;
                                    emit_kind = stk_pkg::K_CMP;
                                end
                                else
                                begin
                                    emit_en    = 1'b1;
                                    emit_kind  = stk_pkg::K_EQ;
                                    reproc_set = 1'b1;
                                end
                            end
                            default:
                                sp_run = 1'b1;
                        endcase
                    end
                end
            end
            S_LEX:
            begin
                rd_addr = idx_reg[ADDR_W-1:0];
                if (out_free)
                begin
                    load              = 1'b1;
                    item.token_kind   = kind_reg;
                    item.lexeme_char  = rd_data_reg;
                    item.char_valid   = 1'b1;
                    item.last         = lex_last;
                    item.truncated    = trunc_reg;
                    idx_next          = idx_inc;
                    rd_addr           = idx_inc[ADDR_W-1:0];
                    if (lex_last)
                        state_next = reproc_reg ? S_REPROC : S_IDLE;
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = reproc_reg ? S_REPROC : S_IDLE;
                end
            end
            S_REPROC:
            begin
                sp_run      = 1'b1;
                reproc_next = 1'b0;
                state_next  = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        // Start-mode scan: the lexeme is empty here, so tokens that end at
        // once carry at most the current byte.
        if (sp_run)
        begin
            mode_next = M_START;
            if (cur_end)
            begin
                one_kind_next  = stk_pkg::K_TERM;
                one_char_next  = 8'h00;
                one_cv_next    = 1'b0;
                one_trunc_next = 1'b0;
                ended_next     = 1'b1;
                state_next     = S_ONE;
            end
            else if (cur_c == stk_pkg::CH_QUOTE)
                mode_next = M_STR;
            else if (cur_c == stk_pkg::CH_SEMI)
            begin
                one_kind_next  = stk_pkg::K_SEMI;
                one_char_next  = 8'h00;
                one_cv_next    = 1'b0;
                one_trunc_next = 1'b0;
                state_next     = S_ONE;
            end
            else if (stk_pkg::is_letter(cur_c) || cur_c == stk_pkg::CH_UNDER ||
                     cur_c == stk_pkg::CH_GT)
            begin
                put_en    = 1'b1;
                mode_next = M_ID;
            end
            else if (cur_c == stk_pkg::CH_EQUAL)
            begin
                put_en    = 1'b1;
                mode_next = M_EQ;
            end
            else if (stk_pkg::is_digit(cur_c))
            begin
                put_en    = 1'b1;
                mode_next = M_NUM;
            end
            else if (cur_c == stk_pkg::CH_PLUS || cur_c == stk_pkg::CH_MINUS ||
                     cur_c == stk_pkg::CH_STAR || cur_c == stk_pkg::CH_SLASH ||
                     cur_c == stk_pkg::CH_LPAREN || cur_c == stk_pkg::CH_RPAREN)
            begin
                if (cur_c == stk_pkg::CH_LPAREN)
                    one_kind_next = stk_pkg::K_LPAREN;
                else if (cur_c == stk_pkg::CH_RPAREN)
                    one_kind_next = stk_pkg::K_RPAREN;
                else
                    one_kind_next = stk_pkg::K_BINOP;
                one_char_next  = cur_c;
                one_cv_next    = 1'b1;
                one_trunc_next = 1'b0;
                state_next     = S_ONE;
            end
        end

        if (put_en)
        begin
            if (len_reg < LEN_W'(stk_pkg::LEXEME_MAX))
            begin
                wr_en    = 1'b1;
                len_next = len_reg + LEN_W'(1);
            end
            else
                ovf_next = 1'b1;
            for (int k = 0; k < stk_pkg::KW_COUNT; k++)
                kw_next[k] = stk_pkg::kw_hit(2'(k), len_reg, cur_c) &&
                             (len_reg == '0 || kw_reg[k]);
        end

        if (emit_en)
        begin
            if (emit_lex && len_next != '0)
            begin
                state_next    = S_LEX;
                emit_len_next = len_next;
                idx_next      = '0;
                kind_next     = emit_kind;
                trunc_next    = ovf_reg;
            end
            else
            begin
                state_next     = S_ONE;
                one_kind_next  = emit_kind;
                one_char_next  = 8'h00;
                one_cv_next    = 1'b0;
                one_trunc_next = emit_lex && ovf_reg;
            end
            reproc_next = reproc_set;
            len_next    = '0;
            ovf_next    = 1'b0;
            mode_next   = M_START;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            lex_mem[wr_addr] <= cur_c;
        rd_data_reg <= lex_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_START;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            line_reg      <= 16'd1;
            col_reg       <= 16'd0;
            ended_reg     <= 1'b0;
            kw_reg        <= '0;
            emit_len_reg  <= '0;
            idx_reg       <= '0;
            trunc_reg     <= 1'b0;
            kind_reg      <= '0;
            one_kind_reg  <= '0;
            one_char_reg  <= '0;
            one_cv_reg    <= 1'b0;
            one_trunc_reg <= 1'b0;
            reproc_reg    <= 1'b0;
            held_ch_reg   <= '0;
            held_end_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            ended_reg     <= ended_next;
            kw_reg        <= kw_next;
            emit_len_reg  <= emit_len_next;
            idx_reg       <= idx_next;
            trunc_reg     <= trunc_next;
            kind_reg      <= kind_next;
            one_kind_reg  <= one_kind_next;
            one_char_reg  <= one_char_next;
            one_cv_reg    <= one_cv_next;
            one_trunc_reg <= one_trunc_next;
            reproc_reg    <= reproc_next;
            held_ch_reg   <= held_ch_next;
            held_end_reg  <= held_end_next;
        end
    end

    stk_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .item  (item),
        .free  (out_free),
        .res   (res)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(stk_pkg::LEXEME_MAX))
        else $error("lexeme length beyond the store");

    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> len_reg == LEN_W'(stk_pkg::LEXEME_MAX))
        else $error("overflow flagged while the store is not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_START |-> len_reg == '0)
        else $error("characters held while between tokens");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LEX |-> emit_len_reg != '0 && idx_reg < emit_len_reg)
        else $error("lexeme read index outside the token");

    assert property (@(posedge clk) disable iff (!rst_n)
        ended_reg |=> ended_reg)
        else $error("end of input was forgotten");

endmodule

>>> hdl/stk_out_stage.sv
module stk_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  stk_pkg::result_t item,
    output logic             free,
    stk_out_if.source        res
);

    logic             valid_reg;
    stk_pkg::result_t item_reg;

    assign free = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            item_reg  <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            item_reg  <= item;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign res.valid        = valid_reg;
    assign res.token_kind   = item_reg.token_kind;
    assign res.lexeme_char  = item_reg.lexeme_char;
    assign res.char_valid   = item_reg.char_valid;
    assign res.last         = item_reg.last;
    assign res.line_number  = item_reg.line_number;
    assign res.column_count = item_reg.column_count;
    assign res.truncated    = item_reg.truncated;

endmodule
